>>> src/mtt_pkg.sv
// Shared types and constants for the move-toward-target block.
package mtt_pkg;

	localparam int COORD_W = 32;
	localparam int SPEED_W = 31;
	localparam int TIME_W = 16;
	localparam int MAG_W = COORD_W + 1;
	localparam int STEP_W = SPEED_W;
	localparam int RAD_W = 2 * MAG_W + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int PROD_W = MAG_W + STEP_W;
	localparam int QUOT_W = MAG_W;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES = QUOT_W;
	localparam int AXES = 3;

	typedef enum logic [1:0] {
		REG_TARGET_X,
		REG_TARGET_Y,
		REG_TARGET_Z,
		REG_MOVE_SPEED
	} mtt_reg_t;

	// Per-item data that rides alongside the square root and divider pipelines.
	typedef struct packed {
		logic [AXES-1:0][COORD_W-1:0] cur;
		logic [AXES-1:0]              neg;
		logic [AXES-1:0][MAG_W-1:0]   mag;
		logic [STEP_W-1:0]            step;
		logic                         arrived;
	} mtt_side_t;

endpackage

>>> src/mtt_if.sv
// Item channel interfaces for positions in and positions out.
interface mtt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] cur_x;
	logic [31:0] cur_y;
	logic [31:0] cur_z;
	logic [15:0] elapsed;

	modport source (output valid, cur_x, cur_y, cur_z, elapsed, input ready);
	modport sink (input valid, cur_x, cur_y, cur_z, elapsed, output ready);
endinterface

interface mtt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_x;
	logic [31:0] new_y;
	logic [31:0] new_z;
	logic        arrived;

	modport source (output valid, new_x, new_y, new_z, arrived, input ready);
	modport sink (input valid, new_x, new_y, new_z, arrived, output ready);
endinterface

>>> src/mtt_front.sv
// Front stages: differences, step length, squared distance and arrival test.
module mtt_front (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          valid_i,
	input  logic [mtt_pkg::AXES-1:0][mtt_pkg::COORD_W-1:0] cur_i,
	input  logic [mtt_pkg::TIME_W-1:0]                    elapsed_i,
	input  logic [mtt_pkg::AXES-1:0][mtt_pkg::COORD_W-1:0] target_i,
	input  logic [mtt_pkg::SPEED_W-1:0]                   speed_i,
	output logic                                          valid_o,
	output logic [mtt_pkg::RAD_W-1:0]                     rad_o,
	output mtt_pkg::mtt_side_t                            side_o
);
	import mtt_pkg::*;

	logic [AXES-1:0][MAG_W-1:0]   diff;
	logic [SPEED_W+TIME_W-1:0]    speed_time;
	logic                         v_s1, v_s2, v_s3;
	mtt_side_t                    side_s1, side_s2, side_s3;
	mtt_side_t                    side_next;
	logic [AXES-1:0][2*MAG_W-1:0] sq_s2;
	logic [2*STEP_W-1:0]          stepsq_s2;
	logic [RAD_W-1:0]             sum;
	logic [RAD_W-1:0]             rad_s3;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			diff[a] = {target_i[a][COORD_W-1], target_i[a]} - {cur_i[a][COORD_W-1], cur_i[a]};
		end
		speed_time = {{TIME_W{1'b0}}, speed_i} * {{SPEED_W{1'b0}}, elapsed_i};
		sum = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
		side_next = side_s2;
		side_next.arrived = (sum <= {{(RAD_W-2*STEP_W){1'b0}}, stepsq_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				side_s1.cur[a] <= cur_i[a];
				side_s1.neg[a] <= diff[a][MAG_W-1];
				side_s1.mag[a] <= diff[a][MAG_W-1] ? (~diff[a] + 1'b1) : diff[a];
			end
			side_s1.step <= speed_time[SPEED_W+TIME_W-1:TIME_W];
			side_s1.arrived <= 1'b0;

			side_s2 <= side_s1;
			for (int a = 0; a < AXES; a++) begin
				sq_s2[a] <= {{MAG_W{1'b0}}, side_s1.mag[a]} * {{MAG_W{1'b0}}, side_s1.mag[a]};
			end
			stepsq_s2 <= {{STEP_W{1'b0}}, side_s1.step} * {{STEP_W{1'b0}}, side_s1.step};

			side_s3 <= side_next;
			rad_s3 <= sum;
		end
	end

	assign valid_o = v_s3;
	assign rad_o = rad_s3;
	assign side_o = side_s3;

endmodule

>>> src/mtt_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module mtt_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_i,
	input  logic [mtt_pkg::RAD_W-1:0]   rad_i,
	input  mtt_pkg::mtt_side_t          side_i,
	output logic                        valid_o,
	output logic [mtt_pkg::ROOT_W-1:0]  root_o,
	output mtt_pkg::mtt_side_t          side_o
);
	import mtt_pkg::*;

	logic              v_s    [1:SQRT_STAGES];
	logic [ROOT_W+1:0] rem_s  [1:SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [1:SQRT_STAGES];
	logic [RAD_W-1:0]  rad_s  [1:SQRT_STAGES];
	mtt_side_t         side_s [1:SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic              vi;
		logic [ROOT_W+1:0] ri;
		logic [ROOT_W-1:0] qi;
		logic [RAD_W-1:0]  ai;
		mtt_side_t         si;
		logic [ROOT_W+3:0] trem;
		logic [ROOT_W+3:0] trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vi = valid_i;
			assign ri = '0;
			assign qi = '0;
			assign ai = rad_i;
			assign si = side_i;
		end else begin : g_next
			assign vi = v_s[k];
			assign ri = rem_s[k];
			assign qi = root_s[k];
			assign ai = rad_s[k];
			assign si = side_s[k];
		end

		// Bring down the next pair of radicand bits and try appending a one.
		assign trem = {ri, ai[RAD_W-1:RAD_W-2]};
		assign trial = {2'b00, qi, 2'b01};
		assign take = trem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? (ROOT_W+2)'(trem - trial) : trem[ROOT_W+1:0];
				root_s[k+1] <= {qi[ROOT_W-2:0], take};
				rad_s[k+1] <= {ai[RAD_W-3:0], 2'b00};
				side_s[k+1] <= si;
			end
		end
	end

	assign valid_o = v_s[SQRT_STAGES];
	assign root_o = root_s[SQRT_STAGES];
	assign side_o = side_s[SQRT_STAGES];

endmodule

>>> src/mtt_div.sv
// Scales each axis by step over distance: one product stage, then restoring division.
module mtt_div (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         valid_i,
	input  logic [mtt_pkg::ROOT_W-1:0]                   dist_i,
	input  mtt_pkg::mtt_side_t                           side_i,
	output logic                                         valid_o,
	output logic [mtt_pkg::AXES-1:0][mtt_pkg::QUOT_W-1:0] quot_o,
	output mtt_pkg::mtt_side_t                           side_o
);
	import mtt_pkg::*;

	logic                         v_sp;
	logic [AXES-1:0][PROD_W-1:0]  prod_sp;
	logic [ROOT_W-1:0]            dist_sp;
	mtt_side_t                    side_sp;

	logic                         v_s    [1:DIV_STAGES];
	logic [AXES-1:0][ROOT_W-1:0]  rem_s  [1:DIV_STAGES];
	logic [AXES-1:0][QUOT_W-1:0]  num_s  [1:DIV_STAGES];
	logic [AXES-1:0][QUOT_W-1:0]  quot_s [1:DIV_STAGES];
	logic [ROOT_W-1:0]            dist_s [1:DIV_STAGES];
	mtt_side_t                    side_s [1:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else if (en) begin
			v_sp <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				prod_sp[a] <= {{STEP_W{1'b0}}, side_i.mag[a]} * {{MAG_W{1'b0}}, side_i.step};
			end
			dist_sp <= dist_i;
			side_sp <= side_i;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic                        vi;
		logic [AXES-1:0][ROOT_W-1:0] ri;
		logic [AXES-1:0][QUOT_W-1:0] ni;
		logic [AXES-1:0][QUOT_W-1:0] qi;
		logic [ROOT_W-1:0]           di;
		mtt_side_t                   si;
		logic [AXES-1:0][ROOT_W:0]   trem;
		logic [AXES-1:0]             take;

		if (k == 0) begin : g_first
			assign vi = v_sp;
			assign di = dist_sp;
			assign si = side_sp;
			assign qi = '0;
			for (genvar a = 0; a < AXES; a++) begin : g_ax
				// The quotient fits in QUOT_W bits, so the upper bits start below dist.
				assign ri[a] = {{(ROOT_W-(PROD_W-QUOT_W)){1'b0}}, prod_sp[a][PROD_W-1:QUOT_W]};
				assign ni[a] = prod_sp[a][QUOT_W-1:0];
			end
		end else begin : g_next
			assign vi = v_s[k];
			assign ri = rem_s[k];
			assign ni = num_s[k];
			assign qi = quot_s[k];
			assign di = dist_s[k];
			assign si = side_s[k];
		end

		for (genvar a = 0; a < AXES; a++) begin : g_cmp
			assign trem[a] = {ri[a], ni[a][QUOT_W-1]};
			assign take[a] = trem[a] >= {1'b0, di};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < AXES; a++) begin
					rem_s[k+1][a] <= take[a] ? ROOT_W'(trem[a] - {1'b0, di}) : trem[a][ROOT_W-1:0];
					num_s[k+1][a] <= {ni[a][QUOT_W-2:0], 1'b0};
					quot_s[k+1][a] <= {qi[a][QUOT_W-2:0], take[a]};
				end
				dist_s[k+1] <= di;
				side_s[k+1] <= si;
			end
		end
	end

	assign valid_o = v_s[DIV_STAGES];
	assign quot_o = quot_s[DIV_STAGES];
	assign side_o = side_s[DIV_STAGES];

	// The offset never exceeds the distance to the target on that axis.
	a_quot_x: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_o && !side_o.arrived) |-> (quot_o[0] <= side_o.mag[0]))
		else $error("x offset exceeds distance");
	a_quot_y: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_o && !side_o.arrived) |-> (quot_o[1] <= side_o.mag[1]))
		else $error("y offset exceeds distance");
	a_quot_z: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_o && !side_o.arrived) |-> (quot_o[2] <= side_o.mag[2]))
		else $error("z offset exceeds distance");

endmodule

>>> src/move_toward_target_3d_unit.sv
// Pipeline order from input accept to result valid: front stages, square root,
// product, divide and output register.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its item is taken, so a stall holds every stage in place.
// Reset: arst_n clears all valid bits and the target and speed registers to zero.
module move_toward_target_3d_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	mtt_in_if.sink         in_item,
	mtt_out_if.source      out_item
);
	import mtt_pkg::*;

	logic [AXES-1:0][COORD_W-1:0] target_q;
	logic [SPEED_W-1:0]           speed_q;
	logic                         en;

	logic                         front_v, sqrt_v, div_v;
	logic [RAD_W-1:0]             front_rad;
	mtt_side_t                    front_side, sqrt_side, div_side;
	logic [ROOT_W-1:0]            sqrt_root;
	logic [AXES-1:0][QUOT_W-1:0]  div_quot;

	logic                         out_v_q;
	logic [AXES-1:0][COORD_W-1:0] new_q;
	logic [AXES-1:0][COORD_W-1:0] cur_q;
	logic                         arrived_q;
	logic [AXES-1:0][COORD_W:0]   moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			speed_q <= '0;
		end else if (cfg_we) begin
			unique case (mtt_reg_t'(cfg_index))
				REG_TARGET_X:   target_q[0] <= cfg_data;
				REG_TARGET_Y:   target_q[1] <= cfg_data;
				REG_TARGET_Z:   target_q[2] <= cfg_data;
				REG_MOVE_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				default:        speed_q <= speed_q;
			endcase
		end
	end

	assign en = !out_v_q || out_item.ready;
	assign in_item.ready = en;

	mtt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_i   (in_item.valid),
		.cur_i     ({in_item.cur_z, in_item.cur_y, in_item.cur_x}),
		.elapsed_i (in_item.elapsed),
		.target_i  (target_q),
		.speed_i   (speed_q),
		.valid_o   (front_v),
		.rad_o     (front_rad),
		.side_o    (front_side)
	);

	mtt_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (front_v),
		.rad_i   (front_rad),
		.side_i  (front_side),
		.valid_o (sqrt_v),
		.root_o  (sqrt_root),
		.side_o  (sqrt_side)
	);

	mtt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sqrt_v),
		.dist_i  (sqrt_root),
		.side_i  (sqrt_side),
		.valid_o (div_v),
		.quot_o  (div_quot),
		.side_o  (div_side)
	);

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			moved[a] = div_side.neg[a]
				? ({div_side.cur[a][COORD_W-1], div_side.cur[a]} - div_quot[a])
				: ({div_side.cur[a][COORD_W-1], div_side.cur[a]} + div_quot[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				new_q[a] <= div_side.arrived ? target_q[a] : moved[a][COORD_W-1:0];
			end
			cur_q <= div_side.cur;
			arrived_q <= div_side.arrived;
		end
	end

	assign out_item.valid = out_v_q;
	assign out_item.new_x = new_q[0];
	assign out_item.new_y = new_q[1];
	assign out_item.new_z = new_q[2];
	assign out_item.arrived = arrived_q;

	a_arrive_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && arrived_q) |-> (new_q == target_q))
		else $error("arrived item is not at target");
	a_between_x: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !arrived_q) |->
		(($signed(cur_q[0]) <= $signed(new_q[0]) && $signed(new_q[0]) <= $signed(target_q[0]))
		|| ($signed(target_q[0]) <= $signed(new_q[0])
		&& $signed(new_q[0]) <= $signed(cur_q[0]))))
		else $error("x left the segment toward target");
	a_between_y: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !arrived_q) |->
		(($signed(cur_q[1]) <= $signed(new_q[1]) && $signed(new_q[1]) <= $signed(target_q[1]))
		|| ($signed(target_q[1]) <= $signed(new_q[1])
		&& $signed(new_q[1]) <= $signed(cur_q[1]))))
		else $error("y left the segment toward target");

endmodule

>>> sim/tb_move_toward_target_3d_unit.sv
// Self-checking testbench for move_toward_target_3d_unit with a scoreboard class.
`timescale 1ns / 100ps

module tb_move_toward_target_3d_unit;
	import mtt_pkg::*;

	localparam int DRAIN_CYCLES = 90;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        arrived;
	} position_t;

	class position_board;
		logic [31:0] tgt_x, tgt_y, tgt_z;
		logic [30:0] speed;
		position_t   expected_positions[$];
		int          mismatches;

		function new();
			tgt_x = '0;
			tgt_y = '0;
			tgt_z = '0;
			speed = '0;
			mismatches = 0;
		endfunction

		function void write_reg(mtt_reg_t idx, logic [31:0] data);
			case (idx)
				REG_TARGET_X: tgt_x = data;
				REG_TARGET_Y: tgt_y = data;
				REG_TARGET_Z: tgt_z = data;
				REG_MOVE_SPEED: speed = data[30:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] advance(logic [31:0] cur, longint d, logic [127:0] mag,
				logic [127:0] step, logic [127:0] dist_len);
			logic [127:0] off;
			off = mag * step / dist_len;
			return (d < 0) ? cur - off[31:0] : cur + off[31:0];
		endfunction

		// Works out the next position for one input item.
		function position_t next_position(logic [31:0] cx, logic [31:0] cy,
				logic [31:0] cz, logic [15:0] t);
			position_t    p;
			longint       dx, dy, dz;
			logic [127:0] mx, my, mz, step, sq, root, cand;
			dx = longint'($signed(tgt_x)) - longint'($signed(cx));
			dy = longint'($signed(tgt_y)) - longint'($signed(cy));
			dz = longint'($signed(tgt_z)) - longint'($signed(cz));
			mx = (dx < 0) ? -dx : dx;
			my = (dy < 0) ? -dy : dy;
			mz = (dz < 0) ? -dz : dz;
			step = (128'(speed) * 128'(t)) >> 16;
			if (step > 128'h7FFF_FFFF)
				step = 128'h7FFF_FFFF;
			sq = mx * mx + my * my + mz * mz;
			if (sq <= step * step) begin
				p.x = tgt_x;
				p.y = tgt_y;
				p.z = tgt_z;
				p.arrived = 1'b1;
			end else begin
				root = '0;
				for (int b = 33; b >= 0; b--) begin
					cand = root | (128'd1 << b);
					if (cand * cand <= sq)
						root = cand;
				end
				p.x = advance(cx, dx, mx, step, root);
				p.y = advance(cy, dy, my, step, root);
				p.z = advance(cz, dz, mz, step, root);
				p.arrived = 1'b0;
			end
			return p;
		endfunction

		function void note_input(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
				logic [15:0] t);
			expected_positions.push_back(next_position(cx, cy, cz, t));
		endfunction

		function void check_result(position_t got);
			position_t want;
			if (expected_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result x=%h y=%h z=%h arrived=%b",
						got.x, got.y, got.z, got.arrived);
				return;
			end
			want = expected_positions.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z
					|| got.arrived !== want.arrived) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
						want.x, want.y, want.z, want.arrived,
						got.x, got.y, got.z, got.arrived);
			end
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	mtt_in_if  in_ch();
	mtt_out_if out_ch();

	position_board board;

	move_toward_target_3d_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_item  (in_ch.sink),
		.out_item (out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Output side: random stalls, mostly short, with long open stretches.
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				@(negedge clk) out_ch.ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end else if (mode < 9) begin
				@(negedge clk) out_ch.ready = 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				@(negedge clk) out_ch.ready = 1'b0;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		position_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.x = out_ch.new_x;
			got.y = out_ch.new_y;
			got.z = out_ch.new_z;
			got.arrived = out_ch.arrived;
			board.check_result(got);
		end
	end

	task automatic write_reg(mtt_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// The last item may still be driven, so drop valid before waiting.
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_target(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] spd);
		wait_drained();
		write_reg(REG_TARGET_X, x);
		write_reg(REG_TARGET_Y, y);
		write_reg(REG_TARGET_Z, z);
		write_reg(REG_MOVE_SPEED, spd);
	endtask

	// Drives one item and holds it until accepted, then idles for a random gap.
	task automatic send_position(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [15:0] t);
		int gap;
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.cur_x = cx;
		in_ch.cur_y = cy;
		in_ch.cur_z = cz;
		in_ch.elapsed = t;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note_input(cx, cy, cz, t);
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] near(logic [31:0] base);
		int kind;
		kind = $urandom_range(0, 3);
		case (kind)
			0: return base + $urandom_range(0, 255) - 128;
			1: return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			2: return base + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] random_elapsed();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [31:0] spd;
		spd = $urandom() & 32'h7FFF_FFFF;
		spd = spd >> $urandom_range(0, 30);
		set_target($urandom(), $urandom(), $urandom(), spd);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_position($urandom(), $urandom(), $urandom(), random_elapsed());
			else
				send_position(near(board.tgt_x), near(board.tgt_y), near(board.tgt_z),
					random_elapsed());
			// Once in a while hold off until the pipeline is empty.
			if (i == count / 2 && $urandom_range(0, 1) == 0)
				wait_drained();
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cur_x = '0;
		in_ch.cur_y = '0;
		in_ch.cur_z = '0;
		in_ch.elapsed = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero target and zero speed.
		send_position(32'h0, 32'h0, 32'h0, 16'hFFFF);
		send_position(32'h0001_0000, 32'h0, 32'h0, 16'hFFFF);
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000);

		set_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000);
		send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
		send_position(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0001);
		send_position(32'h0, 32'h0, 32'h0, 16'h8000);
		send_position(32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001);

		set_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
		send_position(32'h8001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send_position(32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_0000, 16'h8000);
		send_position(32'h8000_0000, 32'h7FFE_0000, 32'h8000_0000, 16'h8000);

		set_target(32'h0, 32'h0, 32'h0, 32'h0000_0001);
		send_position(32'h0, 32'h0, 32'h1, 16'hFFFF);
		send_position(32'h0, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
		send_position(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'hFFFF);
		send_position(32'h0, 32'h0, 32'h0, 16'h0000);

		for (int ph = 0; ph < 7; ph++)
			random_phase(150);

		wait_drained();
		if (board.mismatches == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
